>>> rtl/core/hpps_pkg.sv
package hpps_pkg;

  localparam int MAX_POINTS = 256;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int CFG_W = 31;
  localparam int CFG_IDX_W = 2;
  localparam int F_W = 17;
  localparam int STEPS = 28;
  localparam int VW = 37;
  localparam int RW = 34;
  localparam logic signed [RW-1:0] CORDIC_ONE = RW'(652032874);

  localparam logic [CFG_IDX_W-1:0] REG_SPACING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 2'd2;

  typedef struct packed {
    logic                    sample;
    logic                    ok;
    logic [IDX_W-1:0]        wr_idx;
    logic signed [31:0]      wr_x;
    logic signed [31:0]      wr_y;
    logic signed [31:0]      wr_k;
    logic [F_W-1:0]          f;
    logic [IDX_W-1:0]        a_bm;
    logic [IDX_W-1:0]        a_i;
    logic [IDX_W-1:0]        a_i1;
    logic [IDX_W-1:0]        a_a1;
  } front_t;

  typedef struct packed {
    logic                    ok;
    logic [F_W-1:0]          f;
    logic signed [31:0]      xi;
    logic signed [31:0]      xi1;
    logic signed [31:0]      yi;
    logic signed [31:0]      yi1;
    logic signed [31:0]      ki;
    logic signed [31:0]      ki1;
  } side_t;

  typedef struct packed {
    side_t                   side;
    logic signed [31:0]      xb;
    logic signed [31:0]      xa;
    logic signed [31:0]      yb;
    logic signed [31:0]      ya;
  } pts_t;

  typedef struct packed {
    side_t                   side;
    logic [31:0]             h0;
    logic [31:0]             h1;
    logic signed [RW-1:0]    c0;
    logic signed [RW-1:0]    s0;
    logic signed [RW-1:0]    c1;
    logic signed [RW-1:0]    s1;
  } geo_t;

  function automatic logic [31:0] cordic_angle(input int i);
    logic [31:0] r;
    case (i)
      0: r = 32'h20000000;
      1: r = 32'h12E4051D;
      2: r = 32'h09FB385B;
      3: r = 32'h051111D4;
      4: r = 32'h028B0D43;
      5: r = 32'h0145D7E1;
      6: r = 32'h00A2F61E;
      7: r = 32'h00517C55;
      8: r = 32'h0028BE53;
      9: r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/hpps_channels.sv
interface hpps_in_if;
  import hpps_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   action;
  logic [IDX_W-1:0]       point_index;
  logic signed [31:0]     point_x;
  logic signed [31:0]     point_y;
  logic signed [31:0]     point_curvature;
  logic signed [31:0]     sample_distance;
  modport source(output valid, action, point_index, point_x, point_y, point_curvature,
                 sample_distance, input ready);
  modport sink(input valid, action, point_index, point_x, point_y, point_curvature,
               sample_distance, output ready);
endinterface

interface hpps_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;
  logic signed [31:0] curvature;
  logic signed [31:0] sharpness;
  logic               valid_res;
  modport source(output valid, pos_x, pos_y, heading, curvature, sharpness, valid_res,
                 input ready);
  modport sink(input valid, pos_x, pos_y, heading, curvature, sharpness, valid_res,
               output ready);
endinterface

>>> rtl/core/hpps_front.sv
module hpps_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  hpps_in_if.sink                       in_ch,
  input  logic [hpps_pkg::CNT_W-1:0]    point_count,
  input  logic [hpps_pkg::CFG_W-1:0]    inverse_spacing,
  output logic                          f_valid,
  output hpps_pkg::front_t              f_item
);
  import hpps_pkg::*;

  logic                 a_valid;
  logic                 a_sample;
  logic [IDX_W-1:0]     a_idx;
  logic signed [31:0]   a_x;
  logic signed [31:0]   a_y;
  logic signed [31:0]   a_k;
  logic signed [63:0]   a_p;
  logic [CNT_W-1:0]     a_n;

  logic [CNT_W-1:0]     n_use;
  logic [63:0]          pc;
  logic [63:0]          lim;
  logic [CNT_W-1:0]     nm1;
  logic [CNT_W-1:0]     nm2;
  logic [IDX_W-1:0]     idx;
  logic [F_W-1:0]       f;
  logic [CNT_W-1:0]     ip2;
  front_t               b_next;

  assign n_use = (point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : point_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sample <= in_ch.action;
      a_idx    <= in_ch.point_index;
      a_x      <= in_ch.point_x;
      a_y      <= in_ch.point_y;
      a_k      <= in_ch.point_curvature;
      a_p      <= 64'(signed'(in_ch.sample_distance)) *
                  64'(signed'({1'b0, inverse_spacing}));
      a_n      <= n_use;
    end
  end

  // Clamp the point position to the path and split it into segment and fraction.
  always_comb begin
    nm1 = a_n - CNT_W'(1);
    nm2 = a_n - CNT_W'(2);
    lim = {(64 - CNT_W - 32)'(0), nm1, 32'd0};
    if (a_p[63]) begin
      pc = '0;
    end else if ($unsigned(a_p) > lim) begin
      pc = lim;
    end else begin
      pc = $unsigned(a_p);
    end
    if ({1'b0, pc[32 +: IDX_W]} > nm2) begin
      idx = nm2[IDX_W-1:0];
      f   = F_W'(17'h10000);
    end else begin
      idx = pc[32 +: IDX_W];
      f   = {1'b0, pc[31:16]};
    end
    ip2 = {1'b0, idx} + CNT_W'(2);
    b_next.sample = a_sample;
    b_next.ok     = (a_n >= CNT_W'(2));
    b_next.wr_idx = a_idx;
    b_next.wr_x   = a_x;
    b_next.wr_y   = a_y;
    b_next.wr_k   = a_k;
    b_next.f      = f;
    b_next.a_bm   = (idx == '0) ? '0 : idx - IDX_W'(1);
    b_next.a_i    = idx;
    b_next.a_i1   = idx + IDX_W'(1);
    b_next.a_a1   = (ip2 < a_n) ? ip2[IDX_W-1:0] : nm1[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_item <= b_next;
    end
  end

`ifndef ASSERT_OFF
  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    f_valid && f_item.sample && f_item.ok |-> f_item.f <= F_W'(17'h10000))
    else $error("fraction beyond one segment");
  a_neighbors: assert property (@(posedge clk) disable iff (rst)
    f_valid && f_item.sample && f_item.ok |->
      f_item.a_i1 == f_item.a_i + IDX_W'(1) && f_item.a_bm <= f_item.a_i &&
      f_item.a_a1 >= f_item.a_i1)
    else $error("neighbor addresses out of order");
  a_far_end: assert property (@(posedge clk) disable iff (rst)
    f_valid && f_item.sample && f_item.ok && f_item.f == F_W'(17'h10000) |->
      f_item.a_a1 == f_item.a_i1)
    else $error("full fraction away from the last segment");
`endif

endmodule

>>> rtl/core/hpps_store.sv
module hpps_store (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              f_valid,
  input  hpps_pkg::front_t  f_item,
  output logic              p_valid,
  output hpps_pkg::pts_t    p_item
);
  import hpps_pkg::*;

  // Each coordinate is kept twice so that four neighbors are read per item.
  logic signed [31:0] xa_mem [0:MAX_POINTS-1];
  logic signed [31:0] xb_mem [0:MAX_POINTS-1];
  logic signed [31:0] ya_mem [0:MAX_POINTS-1];
  logic signed [31:0] yb_mem [0:MAX_POINTS-1];
  logic signed [31:0] k_mem  [0:MAX_POINTS-1];

  logic wr_en;

  assign wr_en = adv && f_valid && !f_item.sample;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      xa_mem[f_item.wr_idx] <= f_item.wr_x;
      xb_mem[f_item.wr_idx] <= f_item.wr_x;
      ya_mem[f_item.wr_idx] <= f_item.wr_y;
      yb_mem[f_item.wr_idx] <= f_item.wr_y;
      k_mem[f_item.wr_idx]  <= f_item.wr_k;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_item.xb       <= xa_mem[f_item.a_bm];
      p_item.side.xi  <= xa_mem[f_item.a_i];
      p_item.side.xi1 <= xb_mem[f_item.a_i1];
      p_item.xa       <= xb_mem[f_item.a_a1];
      p_item.yb       <= ya_mem[f_item.a_bm];
      p_item.side.yi  <= ya_mem[f_item.a_i];
      p_item.side.yi1 <= yb_mem[f_item.a_i1];
      p_item.ya       <= yb_mem[f_item.a_a1];
      p_item.side.ki  <= k_mem[f_item.a_i];
      p_item.side.ki1 <= k_mem[f_item.a_i1];
      p_item.side.ok  <= f_item.ok;
      p_item.side.f   <= f_item.f;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= f_valid && f_item.sample;
    end
  end

endmodule

>>> rtl/core/hpps_cordic.sv
module hpps_cordic (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              p_valid,
  input  hpps_pkg::pts_t    p_item,
  output logic              g_valid,
  output hpps_pkg::geo_t    g_item
);
  import hpps_pkg::*;

  logic                 v_valid [0:STEPS];
  side_t                v_side  [0:STEPS];
  logic signed [VW-1:0] vx [0:1][0:STEPS];
  logic signed [VW-1:0] vy [0:1][0:STEPS];
  logic [31:0]          va [0:1][0:STEPS];
  logic                 vz [0:1][0:STEPS];

  logic                 r_valid [0:STEPS];
  side_t                r_side  [0:STEPS];
  logic signed [RW-1:0] rx [0:1][0:STEPS];
  logic signed [RW-1:0] ry [0:1][0:STEPS];
  logic signed [32:0]   ra [0:1][0:STEPS];
  logic                 rf [0:1][0:STEPS];
  logic [31:0]          rh [0:1][0:STEPS];

  logic signed [32:0]   d_x [0:1];
  logic signed [32:0]   d_y [0:1];

  // Lane 0 is the heading at the segment start, lane 1 at its end.
  always_comb begin
    d_x[0] = 33'(signed'(p_item.side.xi1)) - 33'(signed'(p_item.xb));
    d_y[0] = 33'(signed'(p_item.side.yi1)) - 33'(signed'(p_item.yb));
    d_x[1] = 33'(signed'(p_item.xa)) - 33'(signed'(p_item.side.xi));
    d_y[1] = 33'(signed'(p_item.ya)) - 33'(signed'(p_item.side.yi));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= STEPS; s++) begin
        v_valid[s] <= 1'b0;
        r_valid[s] <= 1'b0;
      end
    end else if (adv) begin
      v_valid[0] <= p_valid;
      for (int s = 0; s < STEPS; s++) begin
        v_valid[s+1] <= v_valid[s];
        r_valid[s+1] <= r_valid[s];
      end
      r_valid[0] <= v_valid[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_side[0] <= p_item.side;
      for (int s = 0; s < STEPS; s++) begin
        v_side[s+1] <= v_side[s];
        r_side[s+1] <= r_side[s];
      end
      r_side[0] <= v_side[STEPS];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [31:0] ang;
    logic        flip;

    // A vector in the left half plane is turned by a half turn first.
    always_ff @(posedge clk) begin
      if (adv) begin
        vz[l][0] <= (d_x[l] == '0) && (d_y[l] == '0);
        if (d_x[l][32]) begin
          vx[l][0] <= -VW'(d_x[l]);
          vy[l][0] <= -VW'(d_y[l]);
          va[l][0] <= 32'h8000_0000;
        end else begin
          vx[l][0] <= VW'(d_x[l]);
          vy[l][0] <= VW'(d_y[l]);
          va[l][0] <= 32'h0000_0000;
        end
      end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_vec
      always_ff @(posedge clk) begin
        if (adv) begin
          vz[l][i+1] <= vz[l][i];
          if (!vy[l][i][VW-1] && (vy[l][i] != '0)) begin
            vx[l][i+1] <= vx[l][i] + (vy[l][i] >>> i);
            vy[l][i+1] <= vy[l][i] - (vx[l][i] >>> i);
            va[l][i+1] <= va[l][i] + cordic_angle(i);
          end else begin
            vx[l][i+1] <= vx[l][i] - (vy[l][i] >>> i);
            vy[l][i+1] <= vy[l][i] + (vx[l][i] >>> i);
            va[l][i+1] <= va[l][i] - cordic_angle(i);
          end
        end
      end
    end

    // Angles beyond a quarter turn are folded back and the result negated.
    always_comb begin
      ang  = vz[l][STEPS] ? 32'd0 : va[l][STEPS];
      flip = (ang > 32'h4000_0000) && (ang < 32'hC000_0000);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rh[l][0] <= ang;
        rf[l][0] <= flip;
        rx[l][0] <= CORDIC_ONE;
        ry[l][0] <= '0;
        if (flip) begin
          ra[l][0] <= 33'(signed'({~ang[31], ang[30:0]}));
        end else begin
          ra[l][0] <= 33'(signed'(ang));
        end
      end
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_rot
      always_ff @(posedge clk) begin
        if (adv) begin
          rh[l][i+1] <= rh[l][i];
          rf[l][i+1] <= rf[l][i];
          if (!ra[l][i][32]) begin
            rx[l][i+1] <= rx[l][i] - (ry[l][i] >>> i);
            ry[l][i+1] <= ry[l][i] + (rx[l][i] >>> i);
            ra[l][i+1] <= ra[l][i] - signed'({1'b0, cordic_angle(i)});
          end else begin
            rx[l][i+1] <= rx[l][i] + (ry[l][i] >>> i);
            ry[l][i+1] <= ry[l][i] - (rx[l][i] >>> i);
            ra[l][i+1] <= ra[l][i] + signed'({1'b0, cordic_angle(i)});
          end
        end
      end
    end
  end

  assign g_valid     = r_valid[STEPS];
  assign g_item.side = r_side[STEPS];
  assign g_item.h0   = rh[0][STEPS];
  assign g_item.h1   = rh[1][STEPS];
  assign g_item.c0   = rf[0][STEPS] ? -rx[0][STEPS] : rx[0][STEPS];
  assign g_item.s0   = rf[0][STEPS] ? -ry[0][STEPS] : ry[0][STEPS];
  assign g_item.c1   = rf[1][STEPS] ? -rx[1][STEPS] : rx[1][STEPS];
  assign g_item.s1   = rf[1][STEPS] ? -ry[1][STEPS] : ry[1][STEPS];

endmodule

>>> rtl/core/hpps_blend.sv
module hpps_blend (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic                        g_valid,
  input  hpps_pkg::geo_t              g_item,
  input  logic [hpps_pkg::CFG_W-1:0]  point_spacing,
  input  logic [hpps_pkg::CFG_W-1:0]  inverse_spacing,
  hpps_out_if.source                  out_ch
);
  import hpps_pkg::*;

  // Stage 1: squares of the fraction and its complement, differences.
  logic               e1_valid;
  geo_t               e1;
  logic [F_W-1:0]     e1_g;
  logic [32:0]        e1_gg;
  logic [32:0]        e1_ff;
  logic signed [32:0] e1_dc;
  logic [31:0]        e1_turn;
  logic [F_W-1:0]     gm;

  assign gm = F_W'(17'h10000) - g_item.side.f;

  always_ff @(posedge clk) begin
    if (adv) begin
      e1      <= g_item;
      e1_g    <= gm;
      e1_gg   <= 33'(gm) * 33'(gm);
      e1_ff   <= 33'(g_item.side.f) * 33'(g_item.side.f);
      e1_dc   <= 33'(signed'(g_item.side.ki1)) - 33'(signed'(g_item.side.ki));
      e1_turn <= g_item.h1 - g_item.h0;
    end
  end

  // Stage 2: Hermite basis and the interpolation products.
  logic               e2_valid;
  geo_t               e2;
  logic [F_W-1:0]     e2_h00;
  logic [F_W-1:0]     e2_h01;
  logic [F_W-1:0]     e2_t0;
  logic [F_W-1:0]     e2_t1;
  logic [31:0]        e2_hstep;
  logic signed [34:0] e2_dcf;
  logic [47:0]        e2_mag;
  logic               e2_neg;
  logic [17:0]        two_f;
  logic [50:0]        p00;
  logic [50:0]        p01;
  logic [49:0]        pt0;
  logic [49:0]        pt1;
  logic signed [49:0] ph;
  logic signed [50:0] pdc;
  logic [32:0]        absdc;
  logic [63:0]        pms;

  always_comb begin
    two_f = {e1.side.f, 1'b0};
    p00   = 51'(18'h10000 + two_f) * 51'(e1_gg);
    p01   = 51'(e1_ff) * 51'(18'h30000 - two_f);
    pt0   = 50'(e1.side.f) * 50'(e1_gg);
    pt1   = 50'(e1_ff) * 50'(e1_g);
    ph    = 50'(signed'(e1_turn)) * 50'(signed'({1'b0, e1.side.f}));
    pdc   = 51'(e1_dc) * 51'(signed'({1'b0, e1.side.f}));
    absdc = e1_dc[32] ? $unsigned(-e1_dc) : $unsigned(e1_dc);
    pms   = 64'(absdc) * 64'(inverse_spacing);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e2       <= e1;
      e2_h00   <= p00[48:32];
      e2_h01   <= p01[48:32];
      e2_t0    <= pt0[48:32];
      e2_t1    <= pt1[48:32];
      e2_hstep <= ph[47:16];
      e2_dcf   <= pdc[50:16];
      e2_mag   <= pms[63:16];
      e2_neg   <= e1_dc[32];
    end
  end

  // Stage 3: tangent scales, weighted points, heading, curvature, sharpness.
  logic               e3_valid;
  geo_t               e3;
  logic [31:0]        e3_a;
  logic [31:0]        e3_b;
  logic signed [49:0] e3_hx0;
  logic signed [49:0] e3_hx1;
  logic signed [49:0] e3_hy0;
  logic signed [49:0] e3_hy1;
  logic [15:0]        e3_head;
  logic signed [31:0] e3_cv;
  logic signed [31:0] e3_sh;
  logic [47:0]        pa;
  logic [47:0]        pb;
  logic [31:0]        hd;
  logic [31:0]        hr;
  logic signed [31:0] sh;

  always_comb begin
    pa = 48'(point_spacing) * 48'(e2_t0);
    pb = 48'(point_spacing) * 48'(e2_t1);
    hd = e2.h0 + e2_hstep;
    hr = hd + 32'h0000_8000;
    if (e2_neg) begin
      sh = (e2_mag >= 48'h0000_8000_0000) ? 32'sh8000_0000 : -signed'(e2_mag[31:0]);
    end else begin
      sh = (e2_mag >= 48'h0000_8000_0000) ? 32'sh7FFF_FFFF : signed'(e2_mag[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e3      <= e2;
      e3_a    <= pa[47:16];
      e3_b    <= pb[47:16];
      e3_hx0  <= 50'(signed'({1'b0, e2_h00})) * 50'(signed'(e2.side.xi));
      e3_hx1  <= 50'(signed'({1'b0, e2_h01})) * 50'(signed'(e2.side.xi1));
      e3_hy0  <= 50'(signed'({1'b0, e2_h00})) * 50'(signed'(e2.side.yi));
      e3_hy1  <= 50'(signed'({1'b0, e2_h01})) * 50'(signed'(e2.side.yi1));
      e3_head <= hr[31:16];
      e3_cv   <= sat32(64'(signed'(e2.side.ki)) + 64'(e2_dcf));
      e3_sh   <= sh;
    end
  end

  // Stage 4: tangent products and the point blend.
  logic               e4_valid;
  logic               e4_ok;
  logic signed [66:0] e4_ax;
  logic signed [66:0] e4_bx;
  logic signed [66:0] e4_ay;
  logic signed [66:0] e4_by;
  logic signed [34:0] e4_base_x;
  logic signed [34:0] e4_base_y;
  logic [15:0]        e4_head;
  logic signed [31:0] e4_cv;
  logic signed [31:0] e4_sh;
  logic signed [50:0] sum_x;
  logic signed [50:0] sum_y;

  always_comb begin
    sum_x = 51'(e3_hx0) + 51'(e3_hx1);
    sum_y = 51'(e3_hy0) + 51'(e3_hy1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e4_ok     <= e3.side.ok;
      e4_ax     <= 67'(signed'({1'b0, e3_a})) * 67'(e3.c0);
      e4_bx     <= 67'(signed'({1'b0, e3_b})) * 67'(e3.c1);
      e4_ay     <= 67'(signed'({1'b0, e3_a})) * 67'(e3.s0);
      e4_by     <= 67'(signed'({1'b0, e3_b})) * 67'(e3.s1);
      e4_base_x <= sum_x[50:16];
      e4_base_y <= sum_y[50:16];
      e4_head   <= e3_head;
      e4_cv     <= e3_cv;
      e4_sh     <= e3_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid <= 1'b0;
      e2_valid <= 1'b0;
      e3_valid <= 1'b0;
      e4_valid <= 1'b0;
    end else if (adv) begin
      e1_valid <= g_valid;
      e2_valid <= e1_valid;
      e3_valid <= e2_valid;
      e4_valid <= e3_valid;
    end
  end

  // Output register: position sums and saturation.
  logic               o_valid;
  logic signed [31:0] o_pos_x;
  logic signed [31:0] o_pos_y;
  logic signed [15:0] o_head;
  logic signed [31:0] o_cv;
  logic signed [31:0] o_sh;
  logic               o_res;
  logic signed [67:0] dif_x;
  logic signed [67:0] dif_y;

  always_comb begin
    dif_x = 68'(e4_ax) - 68'(e4_bx);
    dif_y = 68'(e4_ay) - 68'(e4_by);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= e4_valid;
    end
  end

  // A sample with too few points reports all fields zero.
  always_ff @(posedge clk) begin
    if (adv) begin
      o_res <= e4_ok;
      if (e4_ok) begin
        o_pos_x <= sat32(64'(e4_base_x) + 64'(signed'(dif_x[67:30])));
        o_pos_y <= sat32(64'(e4_base_y) + 64'(signed'(dif_y[67:30])));
        o_head  <= signed'(e4_head);
        o_cv    <= e4_cv;
        o_sh    <= e4_sh;
      end else begin
        o_pos_x <= '0;
        o_pos_y <= '0;
        o_head  <= '0;
        o_cv    <= '0;
        o_sh    <= '0;
      end
    end
  end

  assign out_ch.valid     = o_valid;
  assign out_ch.pos_x     = o_pos_x;
  assign out_ch.pos_y     = o_pos_y;
  assign out_ch.heading   = o_head;
  assign out_ch.curvature = o_cv;
  assign out_ch.sharpness = o_sh;
  assign out_ch.valid_res = o_res;

endmodule

>>> rtl/core/hermite_path_point_sampler_top.sv
// Channel  Direction  Carries
// in_ch    sink       action, point_index, point_x/y/curvature, sample_distance
// out_ch   source     pos_x, pos_y, heading, curvature, sharpness, valid_res
// cfg      write      cfg_we, cfg_index, cfg_data (spacing, inverse, point count)
//
// One item enters per cycle while the pipeline is not held; each sample result passes
// through two chained 28-step CORDIC pipelines (atan2, then cos/sin).
// Write items update the point table at the read stage and give no result.
// Reset is synchronous, clears the valid bits and restores the configuration defaults.
// When the result register is full and not taken, the whole pipeline holds.
module hermite_path_point_sampler_top (
  input  logic                            clk,
  input  logic                            rst,
  hpps_in_if.sink                         in_ch,
  hpps_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [hpps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hpps_pkg::CFG_W-1:0]      cfg_data
);
  import hpps_pkg::*;

  logic [CFG_W-1:0] point_spacing;
  logic [CFG_W-1:0] inverse_spacing;
  logic [CNT_W-1:0] point_count;
  logic             adv;
  logic             f_valid;
  front_t           f_item;
  logic             p_valid;
  pts_t             p_item;
  logic             g_valid;
  geo_t             g_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_spacing   <= CFG_W'(65536);
      inverse_spacing <= CFG_W'(65536);
      point_count     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPACING: point_spacing   <= cfg_data;
        REG_INVERSE: inverse_spacing <= cfg_data;
        REG_COUNT:   point_count     <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  hpps_front u_front (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .in_ch           (in_ch),
    .point_count     (point_count),
    .inverse_spacing (inverse_spacing),
    .f_valid         (f_valid),
    .f_item          (f_item)
  );

  hpps_store u_store (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .f_valid (f_valid),
    .f_item  (f_item),
    .p_valid (p_valid),
    .p_item  (p_item)
  );

  hpps_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .p_valid (p_valid),
    .p_item  (p_item),
    .g_valid (g_valid),
    .g_item  (g_item)
  );

  hpps_blend u_blend (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .g_valid         (g_valid),
    .g_item          (g_item),
    .point_spacing   (point_spacing),
    .inverse_spacing (inverse_spacing),
    .out_ch          (out_ch)
  );

endmodule
